// ===== rtl/paau_pkg.sv =====
// Shared types, constants and arithmetic helpers for the particle update pipeline.
// No dependencies; imported by particle_age_and_attribute_update.
`default_nettype none

package paau_pkg;

    localparam int NUM_STAGES = 8;   // stage 0 .. stage 7 (output register)
    localparam int DIV_STAGES = 4;   // quotient bits 15..0, four per stage
    localparam int DIV_BITS   = 4;
    localparam int NUM_LANES  = 8;   // size, three velocity, four colour
    localparam int IN_BYTES   = 40;
    localparam int OUT_BYTES  = 22;

    localparam logic [2:0] ADDR_TIME_STEP = 3'd0;

    typedef struct packed {
        logic               act;
        logic               upd;
        logic               last;
        logic [15:0]        age;
        logic [15:0]        life;
        logic [47:0]        pos;
        logic [47:0]        vel;
        logic [15:0]        ssz;
        logic [15:0]        esz;
        logic [47:0]        svel;
        logic [47:0]        evel;
        logic [31:0]        scol;
        logic [31:0]        ecol;
        logic [2:0][31:0]   pp;
        logic [16:0]        rem;
        logic [15:0]        quo;
        logic               q16;
        logic [15:0]        blend;
        logic [7:0][33:0]   lp;
    } t_stage;

    typedef struct packed {
        logic [16:0] rem;
        logic        qbit;
    } t_div_step;

    // one restoring division step: remainder is below the divisor on entry
    function automatic t_div_step div_step(logic [16:0] rem, logic [15:0] life);
        t_div_step  res;
        logic [16:0] sh;
        sh = {rem[15:0], 1'b0};
        if (sh >= {1'b0, life}) begin
            res.rem  = sh - {1'b0, life};
            res.qbit = 1'b1;
        end else begin
            res.rem  = sh;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    // s + floor((prod + 2^15) / 2^16), not yet clamped
    function automatic logic [19:0] lerp_fin(logic [16:0] s, logic [33:0] prod);
        logic [34:0] t;
        t = {prod[33], prod} + 35'd32768;
        return {{3{s[16]}}, s} + {t[34], t[34:16]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/particle_age_and_attribute_update.sv =====
// Particle age and attribute update: top level, eight-stage pipeline.
// Depends on paau_pkg (types, division step, interpolation helpers).
//
//  channel   | dir | handshake          | payload
//  s (in)    | in  | tvalid/tready      | tdata particle record, tuser is_active, tlast
//  m (out)   | out | tvalid/tready      | tdata updated record, tuser still_active, tlast
//  apb (cfg) | in  | psel/penable/pready| time_step at address 0
//
// One request per cycle sustained while the output is not held. Eight register stages: age,
// position, four divider stages (four quotient bits each), products, rounding. An accepted
// request passes through them in that order and is then held in the output register.
// Each stage advances when empty or when the stage after it advances, so a held
// output fills bubbles first and back-pressure reaches the input last.
// Synchronous active-low reset clears the valid bits and time_step.
`default_nettype none

module particle_age_and_attribute_update #(
    parameter int APB_AW = 3
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    // age, life_time, position, velocity, start_size, end_size,
    // start_velocity, end_velocity, start_color, end_color (low bit up)
    input  wire  [8*paau_pkg::IN_BYTES-1:0]  i_s_tdata,
    input  wire                i_s_tuser,   // is_active
    input  wire                i_s_tlast,   // last_in_frame
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    // new_age, new_position, new_velocity, new_size, new_color, blend (low bit up)
    output logic [8*paau_pkg::OUT_BYTES-1:0] o_m_tdata,
    output logic               o_m_tuser,   // still_active
    output logic               o_m_tlast,   // frame_done
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import paau_pkg::*;

    logic [15:0]  r_ts;
    t_stage       r_stg [NUM_STAGES];
    t_stage       n_stg [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= 16'd0;
        end else if (psel && penable && pwrite && pready
                     && paddr == APB_AW'(ADDR_TIME_STEP)) begin
            r_ts <= pwdata[15:0];
        end
    end
    assign prdata = (paddr == APB_AW'(ADDR_TIME_STEP)) ? {16'd0, r_ts} : 32'd0;

    // ---------------- flow control ----------------
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // ---------------- stage 0: age, liveness, velocity * step ----------------
    always_comb begin
        logic [16:0] sum;
        logic [15:0] nage;
        n_stg[0]      = '0;
        n_stg[0].act  = i_s_tuser;
        n_stg[0].last = i_s_tlast;
        n_stg[0].life = i_s_tdata[31:16];
        n_stg[0].pos  = i_s_tdata[79:32];
        n_stg[0].vel  = i_s_tdata[127:80];
        n_stg[0].ssz  = i_s_tdata[143:128];
        n_stg[0].esz  = i_s_tdata[159:144];
        n_stg[0].svel = i_s_tdata[207:160];
        n_stg[0].evel = i_s_tdata[255:208];
        n_stg[0].scol = i_s_tdata[287:256];
        n_stg[0].ecol = i_s_tdata[319:288];
        sum  = {1'b0, i_s_tdata[15:0]} + {1'b0, r_ts};
        nage = sum[16] ? 16'hFFFF : sum[15:0];
        n_stg[0].age = i_s_tuser ? nage : i_s_tdata[15:0];
        n_stg[0].upd = i_s_tuser && (nage <= i_s_tdata[31:16]);
        for (int i = 0; i < 3; i++) begin
            n_stg[0].pp[i] = 32'($signed(i_s_tdata[80+16*i +: 16]) * $signed({1'b0, r_ts}));
        end
    end

    // ---------------- stage 1: position, divider set-up ----------------
    always_comb begin
        logic [32:0] t;
        logic [25:0] s;
        t = '0;
        s = '0;
        n_stg[1] = r_stg[0];
        if (r_stg[0].upd) begin
            for (int i = 0; i < 3; i++) begin
                t = {r_stg[0].pp[i][31], r_stg[0].pp[i]} + 33'd128;
                s = {{10{r_stg[0].pos[16*i+15]}}, r_stg[0].pos[16*i +: 16]}
                    + {t[32], t[32:8]};
                if (!s[25] && s[24:15] != 10'd0) begin
                    n_stg[1].pos[16*i +: 16] = 16'h7FFF;
                end else if (s[25] && s[24:15] != 10'h3FF) begin
                    n_stg[1].pos[16*i +: 16] = 16'h8000;
                end else begin
                    n_stg[1].pos[16*i +: 16] = s[15:0];
                end
            end
        end
        // age <= life for an updated particle, so the top quotient bit is age == life
        n_stg[1].q16 = r_stg[0].age >= r_stg[0].life;
        n_stg[1].rem = n_stg[1].q16 ? {1'b0, r_stg[0].age} - {1'b0, r_stg[0].life}
                                    : {1'b0, r_stg[0].age};
        n_stg[1].quo = '0;
    end

    // ---------------- stages 2..5: divider ----------------
    for (genvar k = 2; k < 2 + DIV_STAGES; k++) begin : g_div
        always_comb begin
            t_div_step st;
            n_stg[k] = r_stg[k-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                st = div_step(n_stg[k].rem, r_stg[k-1].life);
                n_stg[k].rem = st.rem;
                n_stg[k].quo = {n_stg[k].quo[14:0], st.qbit};
            end
        end
    end

    // ---------------- stage 6: blend and interpolation products ----------------
    logic [NUM_LANES-1:0][16:0] lane_s;
    logic [NUM_LANES-1:0][16:0] lane_e;

    always_comb begin
        lane_s[0] = {1'b0, r_stg[5].ssz};
        lane_e[0] = {1'b0, r_stg[5].esz};
        for (int i = 0; i < 3; i++) begin
            lane_s[1+i] = {r_stg[5].svel[16*i+15], r_stg[5].svel[16*i +: 16]};
            lane_e[1+i] = {r_stg[5].evel[16*i+15], r_stg[5].evel[16*i +: 16]};
        end
        for (int i = 0; i < 4; i++) begin
            lane_s[4+i] = {9'd0, r_stg[5].scol[8*i +: 8]};
            lane_e[4+i] = {9'd0, r_stg[5].ecol[8*i +: 8]};
        end
    end

    always_comb begin
        logic [16:0] d;
        n_stg[6] = r_stg[5];
        n_stg[6].blend = r_stg[5].q16 ? 16'hFFFF : r_stg[5].quo;
        for (int i = 0; i < NUM_LANES; i++) begin
            d = lane_e[i] - lane_s[i];
            n_stg[6].lp[i] = 34'($signed({1'b0, n_stg[6].blend}) * $signed(d));
        end
    end

    // ---------------- stage 7: round, clamp, output select ----------------
    logic [NUM_LANES-1:0][16:0] fin_s;

    always_comb begin
        fin_s[0] = {1'b0, r_stg[6].ssz};
        for (int i = 0; i < 3; i++) begin
            fin_s[1+i] = {r_stg[6].svel[16*i+15], r_stg[6].svel[16*i +: 16]};
        end
        for (int i = 0; i < 4; i++) begin
            fin_s[4+i] = {9'd0, r_stg[6].scol[8*i +: 8]};
        end
    end

    always_comb begin
        logic [19:0] r;
        r = '0;
        n_stg[7] = r_stg[6];
        n_stg[7].ssz  = '0;
        n_stg[7].scol = '0;
        if (r_stg[6].upd) begin
            r = lerp_fin(fin_s[0], r_stg[6].lp[0]);
            n_stg[7].ssz = r[19] ? 16'd0 : (r[18:16] != 3'd0 ? 16'hFFFF : r[15:0]);
            for (int i = 0; i < 3; i++) begin
                r = lerp_fin(fin_s[1+i], r_stg[6].lp[1+i]);
                if (!r[19] && r[18:15] != 4'd0) begin
                    n_stg[7].vel[16*i +: 16] = 16'h7FFF;
                end else if (r[19] && r[18:15] != 4'hF) begin
                    n_stg[7].vel[16*i +: 16] = 16'h8000;
                end else begin
                    n_stg[7].vel[16*i +: 16] = r[15:0];
                end
            end
            for (int i = 0; i < 4; i++) begin
                r = lerp_fin(fin_s[4+i], r_stg[6].lp[4+i]);
                n_stg[7].scol[8*i +: 8] = r[19] ? 8'd0 :
                                          (r[18:8] != 11'd0 ? 8'hFF : r[7:0]);
            end
        end else begin
            n_stg[7].blend = '0;
        end
    end

    // ssz/scol of the last stage carry the final size and colour
    assign o_m_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_tuser  = r_stg[NUM_STAGES-1].upd;
    assign o_m_tlast  = r_stg[NUM_STAGES-1].last;
    assign o_m_tdata  = {r_stg[NUM_STAGES-1].blend,
                         r_stg[NUM_STAGES-1].scol,
                         r_stg[NUM_STAGES-1].ssz,
                         r_stg[NUM_STAGES-1].vel,
                         r_stg[NUM_STAGES-1].pos,
                         r_stg[NUM_STAGES-1].age};

`ifndef NO_ASSERTIONS
    // a particle that did not update carries no size, colour or blend
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[175:112] == '0)
        else $error("dead particle with non-zero attributes");

    // an accepted request always lands in stage 0
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted request lost at stage 0");

    // a stalled output stage backs up the stage before it when that is full
    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready && r_vld[NUM_STAGES-2] |-> !en[NUM_STAGES-2])
        else $error("stage advanced into a held output");
`endif

endmodule

`default_nettype wire
